### rtl/hsl2rgb_pkg.sv
// shared types, widths and fixed-point helpers for the hsl to rgb converter
// no dependencies; imported by hsl_to_rgb_converter and its checker
package hsl2rgb_pkg;

  // channel width; a value v stands for v / FULL
  localparam int CHANNEL_BITS = 16;
  localparam int PROD_BITS    = 2 * CHANNEL_BITS;

  typedef logic [CHANNEL_BITS-1:0] chan_t;
  typedef logic [PROD_BITS-1:0]    prod_t;
  typedef logic [2:0]              sector_t;

  localparam chan_t FULL      = '1;
  localparam prod_t HALF_FULL = PROD_BITS'(FULL >> 1);

  // hue sectors, red through magenta and back
  localparam sector_t SEC_R2Y  = 3'd0;
  localparam sector_t SEC_Y2G  = 3'd1;
  localparam sector_t SEC_G2C  = 3'd2;
  localparam sector_t SEC_C2B  = 3'd3;
  localparam sector_t SEC_B2M  = 3'd4;
  localparam sector_t SEC_M2R  = 3'd5;
  localparam sector_t SEC_WRAP = 3'd6;

  typedef struct packed {
    chan_t hue;
    chan_t saturation;
    chan_t lightness;
  } hsl_t;

  typedef struct packed {
    chan_t red;
    chan_t green;
    chan_t blue;
  } rgb_t;

  // round(p / FULL), half up, for p up to FULL * FULL
  // uses 2^N = FULL + 1: p + HALF_FULL = a*FULL + (a + b), with a + b below 2*FULL + 2
  function automatic chan_t frac_div(input prod_t p);
    prod_t                 x;
    chan_t                 a;
    logic [CHANNEL_BITS:0] s2;
    logic [1:0]            k;
    x  = p + HALF_FULL;
    a  = x[PROD_BITS-1:CHANNEL_BITS];
    s2 = {1'b0, a} + {1'b0, x[CHANNEL_BITS-1:0]};
    if (s2 >= {FULL, 1'b0}) begin
      k = 2'd2;
    end else if (s2 >= {1'b0, FULL}) begin
      k = 2'd1;
    end else begin
      k = 2'd0;
    end
    return a + CHANNEL_BITS'(k);
  endfunction

endpackage

### rtl/hsl_to_rgb_converter.sv
// hsl to rgb pixel converter, six register stages, one pixel per clock unless stalled
// depends on hsl2rgb_pkg for types, sector codes and frac_div
//
//  channel | ports                          | payload
//  --------+--------------------------------+------------------------------
//  input   | in_valid, in_stall, in_data    | hsl_t: hue, saturation, lightness
//  output  | out_valid, out_stall, out_data | rgb_t: red, green, blue
//
// a pixel passes stages 1..5 and the output register; one request per clock
// is sustained unless stalled, set by two multiply/divide pairs in stages 2..5
// all stages move together: a stalled result on the output holds the whole
// pipeline and raises in_stall in the same cycle; nothing is dropped or repeated
// rst_n is synchronous, active low, and clears the stage valid bits only
module hsl_to_rgb_converter
  import hsl2rgb_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  hsl_t in_data,
  output logic out_valid,
  input  logic out_stall,
  output rgb_t out_data
);

  localparam int SUM_BITS = CHANNEL_BITS + 3;

  // stage valid bits
  logic v1_r, v2_r, v3_r, v4_r, v5_r, out_valid_r;
  logic adv;

  // stage 1: lightness distance, hue sector
  chan_t   s1_cm_r, s1_sat_r, s1_l_r, s1_f_r;
  sector_t s1_sec_r;
  // stage 2: chroma product, sector weight
  prod_t   s2_prod_r;
  chan_t   s2_l_r, s2_w_r;
  sector_t s2_sec_r;
  // stage 3: chroma
  chan_t   s3_c_r, s3_l_r, s3_w_r;
  sector_t s3_sec_r;
  // stage 4: x product
  prod_t   s4_prod_r;
  chan_t   s4_c_r, s4_l_r;
  sector_t s4_sec_r;
  // stage 5: x
  chan_t   s5_x_r, s5_c_r, s5_l_r;
  sector_t s5_sec_r;
  rgb_t    out_data_r;

  // stage 1 combinational, sector weight and output mapping
  logic [CHANNEL_BITS:0]   twol;
  chan_t                   lum_dist;
  chan_t                   cm_nxt;
  logic [CHANNEL_BITS+2:0] hp;
  logic [2:0]              hq;
  logic [CHANNEL_BITS:0]   hsum;
  logic                    hge;
  sector_t                 sec_raw;
  sector_t                 sec_nxt;
  chan_t                   f_raw;
  chan_t                   f_nxt;
  chan_t                   w_nxt;
  chan_t                   r_ch, g_ch, b_ch;
  rgb_t                    out_nxt;

  assign adv       = ~out_valid_r | ~out_stall;
  assign in_stall  = ~adv;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // chan + m in half units, rounded half up, clamped to [0, FULL]
  function automatic chan_t finish(input chan_t ch, input chan_t l, input chan_t c);
    logic [SUM_BITS-1:0] t;
    logic [SUM_BITS-1:0] u;
    t = {2'b00, ch, 1'b0} + {2'b00, l, 1'b0} + SUM_BITS'(1);
    if (t < SUM_BITS'(c)) begin
      return '0;
    end
    u = (t - SUM_BITS'(c)) >> 1;
    if (u > SUM_BITS'(FULL)) begin
      return FULL;
    end
    return u[CHANNEL_BITS-1:0];
  endfunction

  always_comb begin
    twol = {in_data.lightness, 1'b0};
    if (twol >= {1'b0, FULL}) begin
      lum_dist = CHANNEL_BITS'(twol - {1'b0, FULL});
    end else begin
      lum_dist = CHANNEL_BITS'({1'b0, FULL} - twol);
    end
    cm_nxt = FULL - lum_dist;

    // 6h / FULL using 2^N = FULL + 1
    hp   = ({3'b000, in_data.hue} << 2) + ({3'b000, in_data.hue} << 1);
    hq   = hp[CHANNEL_BITS+2:CHANNEL_BITS];
    hsum = {1'b0, hp[CHANNEL_BITS-1:0]} + (CHANNEL_BITS+1)'(hq);
    hge  = (hsum >= {1'b0, FULL});
    sec_raw = hq + 3'(hge);
    if (hge) begin
      f_raw = CHANNEL_BITS'(hsum - {1'b0, FULL});
    end else begin
      f_raw = hsum[CHANNEL_BITS-1:0];
    end
    // hue of a full circle wraps to red
    if (sec_raw >= SEC_WRAP) begin
      sec_nxt = SEC_R2Y;
      f_nxt   = '0;
    end else begin
      sec_nxt = sec_raw;
      f_nxt   = f_raw;
    end
  end

  assign w_nxt = s1_sec_r[0] ? (FULL - s1_f_r) : s1_f_r;

  always_comb begin
    case (s5_sec_r)
      SEC_R2Y: begin
        r_ch = s5_c_r; g_ch = s5_x_r; b_ch = '0;
      end
      SEC_Y2G: begin
        r_ch = s5_x_r; g_ch = s5_c_r; b_ch = '0;
      end
      SEC_G2C: begin
        r_ch = '0; g_ch = s5_c_r; b_ch = s5_x_r;
      end
      SEC_C2B: begin
        r_ch = '0; g_ch = s5_x_r; b_ch = s5_c_r;
      end
      SEC_B2M: begin
        r_ch = s5_x_r; g_ch = '0; b_ch = s5_c_r;
      end
      default: begin
        r_ch = s5_c_r; g_ch = '0; b_ch = s5_x_r;
      end
    endcase
    out_nxt.red   = finish(r_ch, s5_l_r, s5_c_r);
    out_nxt.green = finish(g_ch, s5_l_r, s5_c_r);
    out_nxt.blue  = finish(b_ch, s5_l_r, s5_c_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      v5_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      v1_r        <= in_valid;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      v4_r        <= v3_r;
      v5_r        <= v4_r;
      out_valid_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_cm_r    <= cm_nxt;
      s1_sat_r   <= in_data.saturation;
      s1_l_r     <= in_data.lightness;
      s1_f_r     <= f_nxt;
      s1_sec_r   <= sec_nxt;

      s2_prod_r  <= PROD_BITS'(s1_cm_r) * PROD_BITS'(s1_sat_r);
      s2_l_r     <= s1_l_r;
      s2_w_r     <= w_nxt;
      s2_sec_r   <= s1_sec_r;

      s3_c_r     <= frac_div(s2_prod_r);
      s3_l_r     <= s2_l_r;
      s3_w_r     <= s2_w_r;
      s3_sec_r   <= s2_sec_r;

      s4_prod_r  <= PROD_BITS'(s3_c_r) * PROD_BITS'(s3_w_r);
      s4_c_r     <= s3_c_r;
      s4_l_r     <= s3_l_r;
      s4_sec_r   <= s3_sec_r;

      s5_x_r     <= frac_div(s4_prod_r);
      s5_c_r     <= s4_c_r;
      s5_l_r     <= s4_l_r;
      s5_sec_r   <= s4_sec_r;

      out_data_r <= out_nxt;
    end
  end

endmodule

### rtl/hsl2rgb_checker.sv
// port-level checks for hsl_to_rgb_converter, bound into that module
// depends on hsl2rgb_pkg for the payload types
module hsl2rgb_checker
  import hsl2rgb_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input rgb_t out_data
);

  // a stalled result holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // output stall freezes the whole pipe
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |-> in_stall)
    else $error("request taken while output stalled");

  // empty output never blocks the input
  assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty output");

  // an accepted request reaches the output when no stall or reset comes between
  assert property (@(posedge clk) disable iff (!rst_n)
    $past(in_valid && !in_stall && rst_n, 6) &&
    !$past(in_stall, 5) && !$past(in_stall, 4) && !$past(in_stall, 3) &&
    !$past(in_stall, 2) && !$past(in_stall, 1) &&
    $past(rst_n, 5) && $past(rst_n, 4) && $past(rst_n, 3) &&
    $past(rst_n, 2) && $past(rst_n, 1) |-> out_valid)
    else $error("request lost in pipeline");

endmodule

bind hsl_to_rgb_converter hsl2rgb_checker u_hsl2rgb_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
